// File: sv/euler_sde_path_step_macros.svh
// Assertion macros shared by the path step RTL.
`ifndef EULER_SDE_PATH_STEP_MACROS_SVH
`define EULER_SDE_PATH_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ESDE_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESDE_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/esde_pkg.sv
// Shared constants, types and saturation helper for the path step block.
package esde_pkg;

  localparam int NumNoisesDef = 4;
  localparam int FracBitsDef  = 24;
  localparam int DataW        = 32;
  localparam int TsW          = 25;
  localparam int NoiseSlots   = 4;
  localparam int SlotW        = 2;
  localparam int MapW         = 8;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;
  localparam int InTdataW     = 192;
  localparam int QueueDepth   = 2;
  localparam int ProdW        = 64;

  localparam logic [MapW-1:0] NoiseMapRst = 8'hE4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RFR  = 3'd0,
    REG_VOL0 = 3'd1,
    REG_VOL1 = 3'd2,
    REG_VOL2 = 3'd3,
    REG_VOL3 = 3'd4,
    REG_MAP  = 3'd5,
    REG_INIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    clip;
  } sat_t;

  // Clip a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [ProdW-1:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val  = 32'sh7FFFFFFF;
      r.clip = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val  = 32'sh80000000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[DataW-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: sv/esde_front.sv
// Input side: accepts step items, applies the noise map and packs a queue entry.
module esde_front #(
  parameter int NUM_NOISES = esde_pkg::NumNoisesDef
) (
  input  logic                                      s_tvalid_i,
  output logic                                      s_tready_o,
  input  logic [esde_pkg::InTdataW-1:0]             s_tdata_i,
  input  logic                                      s_tlast_i,
  input  logic [esde_pkg::MapW-1:0]                 noise_map_i,
  input  logic                                      q_full_i,
  output logic                                      q_push_o,
  output logic [esde_pkg::TsW+esde_pkg::DataW*(NUM_NOISES+1):0] q_data_o
);

  localparam int TsW   = esde_pkg::TsW;
  localparam int DW    = esde_pkg::DataW;
  localparam int NoiseLo = TsW + DW;

  logic [DW-1:0] noise [esde_pkg::NoiseSlots];
  logic [DW-1:0] lane  [NUM_NOISES];

  for (genvar s = 0; s < esde_pkg::NoiseSlots; s++) begin : g_slot
    assign noise[s] = s_tdata_i[NoiseLo + DW*s +: DW];
  end

  // each volatility lane picks its own noise slot
  for (genvar k = 0; k < NUM_NOISES; k++) begin : g_lane
    assign lane[k] = noise[noise_map_i[esde_pkg::SlotW*k +: esde_pkg::SlotW]];
    assign q_data_o[NoiseLo + DW*k +: DW] = lane[k];
  end

  assign q_data_o[TsW-1:0]      = s_tdata_i[TsW-1:0];
  assign q_data_o[TsW +: DW]    = s_tdata_i[TsW +: DW];
  assign q_data_o[TsW + DW*(NUM_NOISES+1)] = s_tlast_i;

  assign s_tready_o = ~q_full_i;
  assign q_push_o   = s_tvalid_i & ~q_full_i;

endmodule

// File: sv/esde_fifo.sv
// Small flop-based queue between front and back.
module esde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = esde_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/esde_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module esde_sqrt #(
  parameter int IN_W = esde_pkg::TsW + esde_pkg::FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [IN_W-1:0]         radicand_i,
  output logic                    done_o,
  output logic [(IN_W+1)/2-1:0]   root_o
);

  localparam int RootW = (IN_W + 1) / 2;
  localparam int PadW  = 2 * RootW;
  localparam int CntW  = $clog2(RootW + 1);

  logic [PadW-1:0]  x_q, x_d;
  logic [RootW:0]   rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RootW+2:0] rem_sh, trial, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, x_q[PadW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign fits    = (rem_sh >= trial);

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      x_d    = PadW'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      x_d    = x_q << 2;
      rem_d  = fits ? rem_sub[RootW:0] : rem_sh[RootW:0];
      root_d = {root_q[RootW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: sv/esde_back.sv
// Execution side: sequences the shared multiplier, rounds, saturates, accumulates.
`include "euler_sde_path_step_macros.svh"

module esde_back #(
  parameter int NUM_NOISES = esde_pkg::NumNoisesDef,
  parameter int FRAC_BITS  = esde_pkg::FracBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      q_valid_i,
  input  logic [esde_pkg::TsW+esde_pkg::DataW*(NUM_NOISES+1):0] q_data_i,
  output logic                                      q_pop_o,
  input  logic signed [esde_pkg::DataW-1:0]         rfr_i,
  input  logic signed [esde_pkg::DataW-1:0]         vol_i [NUM_NOISES],
  input  logic signed [esde_pkg::DataW-1:0]         init_i,
  output logic                                      m_tvalid_o,
  input  logic                                      m_tready_i,
  output logic [esde_pkg::DataW-1:0]                m_tdata_o,
  output logic                                      m_tuser_o,
  output logic                                      m_tlast_o
);

  localparam int TsW     = esde_pkg::TsW;
  localparam int DW      = esde_pkg::DataW;
  localparam int PW      = esde_pkg::ProdW;
  localparam int NoiseLo = TsW + DW;
  localparam int LastPos = TsW + DW * (NUM_NOISES + 1);
  localparam int SqInW   = TsW + FRAC_BITS;
  localparam int SqW     = (SqInW + 1) / 2;
  localparam int OpW     = $clog2(NUM_NOISES + 4);
  localparam int LaneW   = (NUM_NOISES > 1) ? $clog2(NUM_NOISES) : 1;

  // operation order: one per noise lane, then the four chained products
  localparam logic [OpW-1:0] OP_RG    = OpW'(NUM_NOISES);
  localparam logic [OpW-1:0] OP_DRIFT = OpW'(NUM_NOISES + 1);
  localparam logic [OpW-1:0] OP_SG    = OpW'(NUM_NOISES + 2);
  localparam logic [OpW-1:0] OP_DIFF  = OpW'(NUM_NOISES + 3);

  localparam logic signed [PW-1:0] RndHalf = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RND  = 5'b00100,
    S_ACC  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [OpW-1:0] op_q, op_d;

  logic [TsW-1:0]           ts_q, ts_d;
  logic signed [DW-1:0]     g_q, g_d;
  logic signed [DW-1:0]     lane_q [NUM_NOISES];
  logic signed [DW-1:0]     lane_d [NUM_NOISES];
  logic                     last_q, last_d;
  logic signed [PW-1:0]     prod_q, prod_d, rnd_q, rnd_d, acc_q, acc_d;
  logic signed [DW-1:0]     dot_q, dot_d, rg_q, rg_d, drift_q, drift_d;
  logic signed [DW-1:0]     sg_q, sg_d, diff_q, diff_d;
  logic                     flag_q, flag_d;
  logic signed [DW-1:0]     run_q, run_d;
  logic                     primed_q, primed_d;
  logic                     out_valid_q, out_valid_d;
  logic [DW-1:0]            out_data_q, out_data_d;
  logic                     out_user_q, out_user_d, out_last_q, out_last_d;

  logic signed [DW-1:0]     mul_a, mul_b, base;
  logic signed [DW+1:0]     sum;
  esde_pkg::sat_t           sat_r, sat_dot, sat_fin;
  logic                     out_free, load, sq_done;
  logic [SqW-1:0]           sq_root;
  logic [SqInW-1:0]         sq_rad;

  assign out_free = ~out_valid_q | m_tready_i;
  assign load     = (state_q == S_IDLE) & q_valid_i;
  assign q_pop_o  = load;
  assign sq_rad   = {q_data_i[TsW-1:0], {FRAC_BITS{1'b0}}};

  esde_sqrt #(.IN_W(SqInW)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (load),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // multiplier operand select
  always_comb begin
    if (op_q < OP_RG) begin
      mul_a = vol_i[op_q[LaneW-1:0]];
      mul_b = lane_q[op_q[LaneW-1:0]];
    end else begin
      case (op_q)
        OP_DRIFT: begin
          mul_a = rg_q;
          mul_b = signed'(DW'(ts_q));
        end
        OP_SG: begin
          mul_a = signed'(DW'(sq_root));
          mul_b = g_q;
        end
        OP_DIFF: begin
          mul_a = sg_q;
          mul_b = dot_q;
        end
        default: begin
          mul_a = rfr_i;
          mul_b = g_q;
        end
      endcase
    end
  end

  assign sat_r   = esde_pkg::sat32(rnd_q);
  assign sat_dot = esde_pkg::sat32(acc_q);
  assign base    = primed_q ? run_q : init_i;
  assign sum     = (DW+2)'(base) + (DW+2)'(drift_q) + (DW+2)'(diff_q);
  assign sat_fin = esde_pkg::sat32(PW'(sum));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ts_d        = ts_q;
    g_d         = g_q;
    lane_d      = lane_q;
    last_d      = last_q;
    prod_d      = prod_q;
    rnd_d       = rnd_q;
    acc_d       = acc_q;
    dot_d       = dot_q;
    rg_d        = rg_q;
    drift_d     = drift_q;
    sg_d        = sg_q;
    diff_d      = diff_q;
    flag_d      = flag_q;
    run_d       = run_q;
    primed_d    = primed_q;
    out_valid_d = out_valid_q & ~m_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          ts_d   = q_data_i[TsW-1:0];
          g_d    = signed'(q_data_i[TsW +: DW]);
          for (int k = 0; k < NUM_NOISES; k++) begin
            lane_d[k] = signed'(q_data_i[NoiseLo + DW*k +: DW]);
          end
          last_d  = q_data_i[LastPos];
          op_d    = '0;
          acc_d   = '0;
          flag_d  = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // the gearing-root product waits for the square-root unit
        if (op_q != OP_SG || sq_done) begin
          prod_d  = mul_a * mul_b;
          state_d = S_RND;
        end
      end
      S_RND: begin
        rnd_d   = (prod_q + RndHalf) >>> FRAC_BITS;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (op_q < OP_RG) begin
          acc_d = acc_q + rnd_q;
        end else begin
          case (op_q)
            OP_DRIFT: drift_d = sat_r.val;
            OP_SG:    sg_d    = sat_r.val;
            OP_DIFF:  diff_d  = sat_r.val;
            default: begin
              rg_d  = sat_r.val;
              dot_d = sat_dot.val;
            end
          endcase
          flag_d = flag_q | sat_r.clip | ((op_q == OP_RG) & sat_dot.clip);
        end
        if (op_q == OP_DIFF) begin
          state_d = S_FIN;
        end else begin
          op_d    = op_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_fin.val;
          out_user_d  = flag_q | sat_fin.clip;
          out_last_d  = last_q;
          run_d       = sat_fin.val;
          primed_d    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      run_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      run_q       <= run_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q       <= ts_d;
    g_q        <= g_d;
    lane_q     <= lane_d;
    last_q     <= last_d;
    prod_q     <= prod_d;
    rnd_q      <= rnd_d;
    acc_q      <= acc_d;
    dot_q      <= dot_d;
    rg_q       <= rg_d;
    drift_q    <= drift_d;
    sg_q       <= sg_d;
    diff_q     <= diff_d;
    flag_q     <= flag_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  `ESDE_ASSERT_NXT(a_fin_emits, (state_q == S_FIN) && out_free, out_valid_q && (state_q == S_IDLE), "finished step did not reach the output register")
  `ESDE_ASSERT_IMP(a_out_primed, out_valid_q, primed_q, "result shown before the path was primed")
  `ESDE_ASSERT_IMP(a_root_ready, state_q == S_FIN, sq_done, "step finished without a square root")

endmodule

// File: sv/euler_sde_path_step.sv
// Timing: the square-root unit (one root bit per cycle, ceil((25+FRAC_BITS)/2)
//   bits) sets the time from input transfer to tvalid at default parameters.
// Throughput: one item in the back end at a time; a two-entry queue lets the
//   input side take items while it works.
// Reset: config registers go to their defaults (noise map = identity), the held
//   path value clears and the next step starts from initial_value.
module euler_sde_path_step #(
  parameter int NUM_NOISES = esde_pkg::NumNoisesDef,
  parameter int FRAC_BITS  = esde_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [esde_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [esde_pkg::CfgDataW-1:0]     cfg_data_i,
  // step items in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // time_step[24:0], gearing[56:25], noise_0[88:57], noise_1[120:89],
  // noise_2[152:121], noise_3[184:153], zero pad [191:185]
  input  logic [esde_pkg::InTdataW-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,    // last_step
  // path values out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [esde_pkg::DataW-1:0]        m_axis_tdata,    // path_value[31:0]
  output logic [0:0]                        m_axis_tuser,    // saturated[0]
  output logic                              m_axis_tlast     // path_done
);

  localparam int DW     = esde_pkg::DataW;
  localparam int EntryW = esde_pkg::TsW + DW * (NUM_NOISES + 1) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands at any enabled edge; the host keeps
  // them steady while a step is in flight.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]        rfr_q, rfr_d, init_q, init_d;
  logic signed [DW-1:0]        vol_q [esde_pkg::NoiseSlots];
  logic signed [DW-1:0]        vol_d [esde_pkg::NoiseSlots];
  logic [esde_pkg::MapW-1:0]   map_q, map_d;

  always_comb begin
    rfr_d  = rfr_q;
    vol_d  = vol_q;
    map_d  = map_q;
    init_d = init_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        esde_pkg::REG_RFR:  rfr_d    = signed'(cfg_data_i);
        esde_pkg::REG_VOL0: vol_d[0] = signed'(cfg_data_i);
        esde_pkg::REG_VOL1: vol_d[1] = signed'(cfg_data_i);
        esde_pkg::REG_VOL2: vol_d[2] = signed'(cfg_data_i);
        esde_pkg::REG_VOL3: vol_d[3] = signed'(cfg_data_i);
        esde_pkg::REG_MAP:  map_d    = cfg_data_i[esde_pkg::MapW-1:0];
        esde_pkg::REG_INIT: init_d   = signed'(cfg_data_i);
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rfr_q  <= '0;
      vol_q  <= '{default: '0};
      map_q  <= esde_pkg::NoiseMapRst;
      init_q <= '0;
    end else begin
      rfr_q  <= rfr_d;
      vol_q  <= vol_d;
      map_q  <= map_d;
      init_q <= init_d;
    end
  end

  // only the first NUM_NOISES volatilities feed the dot product
  logic signed [DW-1:0] vol_lane [NUM_NOISES];
  for (genvar k = 0; k < NUM_NOISES; k++) begin : g_vol
    assign vol_lane[k] = vol_q[k];
  end

  // ---------------------------------------------------------------------------
  // Front end -> queue -> back end
  // ---------------------------------------------------------------------------
  logic              q_full, q_empty, q_push, q_pop;
  logic [EntryW-1:0] q_wdata, q_rdata;

  esde_front #(.NUM_NOISES(NUM_NOISES)) u_front (
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .noise_map_i (map_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  esde_fifo #(.WIDTH(EntryW), .DEPTH(esde_pkg::QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  // back end: lane products, drift and diffusion chains, final accumulate
  esde_back #(.NUM_NOISES(NUM_NOISES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (~q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .rfr_i      (rfr_q),
    .vol_i      (vol_lane),
    .init_i     (init_q),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser[0]),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
